[sv/lcpl_pkg.sv]
`default_nettype none

package lcpl_pkg;

    // channel count default
    localparam int LCPL_CHANNELS = 4;

    // field widths
    localparam int CH_FW   = 2;
    localparam int CUR_W   = 16;
    localparam int TIME_W  = 32;
    localparam int REG_W   = 16;
    localparam int ACC_W   = 24;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_RANGE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EVEN_RAMP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ODD_RAMP    = 3'd5;

    // register reset values
    localparam logic [REG_W-1:0] RST_P_GAIN      = 16'd6554;
    localparam logic [REG_W-1:0] RST_MAX_STEP    = 16'd10;
    localparam logic [REG_W-1:0] RST_PWM_RANGE   = 16'd1000;
    localparam logic [REG_W-1:0] RST_MAX_CURRENT = 16'd4096;
    localparam logic [REG_W-1:0] RST_EVEN_RAMP   = 16'd2560;
    localparam logic [REG_W-1:0] RST_ODD_RAMP    = 16'd5120;

    // below this target (about 10 mA) the duty is cleared
    localparam logic [REG_W-1:0] MIN_TARGET = 16'd41;

    // divider: quotient bits retired per cycle and number of cycles
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = REG_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [REG_W-1:0] p_gain;
        logic [REG_W-1:0] max_step;
        logic [REG_W-1:0] pwm_range;
        logic [REG_W-1:0] max_current;
        logic [REG_W-1:0] even_ramp;
        logic [REG_W-1:0] odd_ramp;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic tgt;
        logic div_step;
        logic mul1;
        logic mul2;
        logic rnd;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

[sv/lcpl_cfg.sv]
`default_nettype none

module lcpl_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [lcpl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lcpl_pkg::REG_W-1:0]      i_cfg_data,
    output lcpl_pkg::t_cfg                       o_cfg
);
    import lcpl_pkg::*;

    t_cfg r_cfg;

    // writes always accepted
    assign o_cfg_ready = 1'b1;

    // register file, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p_gain      <= RST_P_GAIN;
            r_cfg.max_step    <= RST_MAX_STEP;
            r_cfg.pwm_range   <= RST_PWM_RANGE;
            r_cfg.max_current <= RST_MAX_CURRENT;
            r_cfg.even_ramp   <= RST_EVEN_RAMP;
            r_cfg.odd_ramp    <= RST_ODD_RAMP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_P_GAIN:      r_cfg.p_gain      <= i_cfg_data;
                CFG_MAX_STEP:    r_cfg.max_step    <= i_cfg_data;
                CFG_PWM_RANGE:   r_cfg.pwm_range   <= i_cfg_data;
                CFG_MAX_CURRENT: r_cfg.max_current <= i_cfg_data;
                CFG_EVEN_RAMP:   r_cfg.even_ramp   <= i_cfg_data;
                CFG_ODD_RAMP:    r_cfg.odd_ramp    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[sv/lcpl_ctrl.sv]
`default_nettype none

module lcpl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire lcpl_pkg::t_sts i_sts,
    output lcpl_pkg::t_cmd      o_cmd
);
    import lcpl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TGT  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_RND  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DIV_CNT_W-1:0] n_div_cnt;
    t_cmd                 cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_TGT;
                end
            end
            S_TGT: begin
                cmd.tgt = 1'b1;
                n_state = i_sts.need_div ? S_DIV : S_MUL1;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                cmd.mul1 = 1'b1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul2 = 1'b1;
                n_state  = S_RND;
            end
            S_RND: begin
                cmd.rnd = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (!i_sts.out_busy) begin
                    cmd.commit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // divider step count
    assign n_div_cnt = (r_state == S_DIV) ? r_div_cnt + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

[sv/lcpl_dp.sv]
`default_nettype none

module lcpl_dp #(
    parameter int CHANNELS = lcpl_pkg::LCPL_CHANNELS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lcpl_pkg::t_cfg                    i_cfg,
    input  wire lcpl_pkg::t_cmd                    i_cmd,
    output lcpl_pkg::t_sts                         o_sts,
    input  wire logic [lcpl_pkg::CH_FW-1:0]        i_channel,
    input  wire logic signed [lcpl_pkg::CUR_W-1:0] i_measured_current,
    input  wire logic signed [lcpl_pkg::TIME_W-1:0] i_time_rel_wakeup,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output logic [lcpl_pkg::CH_FW-1:0]             o_out_channel,
    output logic [lcpl_pkg::REG_W-1:0]             o_pwm_duty,
    output logic [lcpl_pkg::REG_W-1:0]             o_setpoint
);
    import lcpl_pkg::*;

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD1_W = REG_W + 1 + REG_W;
    localparam int PROD2_W = PROD1_W + REG_W;
    localparam int RND_W   = PROD2_W - REG_W;

    // latched item
    logic [CH_FW-1:0]         r_ch;
    logic signed [CUR_W-1:0]  r_meas;
    logic signed [TIME_W-1:0] r_t;

    // target and divider
    logic [REG_W-1:0] r_target;
    logic [REG_W-1:0] r_rem;
    logic [REG_W-1:0] r_dvd;

    // correction pipeline
    logic               r_err_neg;
    logic               r_low;
    logic [PROD1_W-1:0] r_prod1;
    logic [PROD2_W-1:0] r_prod2;
    logic signed [REG_W:0] r_delta;

    // per-channel stored duty
    logic [ACC_W-1:0] r_acc [CHANNELS];

    // output register
    logic             r_out_valid;
    logic [CH_FW-1:0] r_out_ch;
    logic [REG_W-1:0] r_out_duty;
    logic [REG_W-1:0] r_out_tgt;

    logic [REG_W-1:0]    ramp;
    logic signed [TIME_W:0] t_plus_r;
    logic                t_pos;
    logic                below;
    logic [REG_W-1:0]    ramp_arg;
    logic [2*REG_W-1:0]  tgt_prod;
    logic [REG_W:0]      rem_v;
    logic [REG_W-1:0]    dvd_v;
    logic [REG_W-1:0]    quo_v;
    logic signed [REG_W+1:0] err;
    logic [REG_W+1:0]    err_abs;
    logic [PROD2_W-1:0]  rnd_sum;
    logic [RND_W-1:0]    rounded;
    logic [REG_W-1:0]    lim;
    logic                ch_ok;
    logic [CH_W-1:0]     idx;
    logic [ACC_W-1:0]    acc_rd;
    logic signed [ACC_W:0] acc_sum;
    logic [ACC_W-1:0]    acc_sat;
    logic [ACC_W-1:0]    acc_new;
    logic [REG_W-1:0]    duty;

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch   <= i_channel;
            r_meas <= i_measured_current;
            r_t    <= i_time_rel_wakeup;
        end
    end

    // target case split: after wake-up, before the ramp, or on the ramp
    assign ramp     = r_ch[0] ? i_cfg.odd_ramp : i_cfg.even_ramp;
    assign t_pos    = !r_t[TIME_W-1];
    assign t_plus_r = $signed({r_t[TIME_W-1], r_t}) + $signed({{(TIME_W-REG_W+1){1'b0}}, ramp});
    assign below    = t_plus_r[TIME_W];
    assign ramp_arg = r_t[REG_W-1:0] + ramp;
    assign tgt_prod = (2*REG_W)'(i_cfg.max_current) * (2*REG_W)'(ramp_arg);

    assign o_sts = '{need_div: (!t_pos && !below), out_busy: (r_out_valid && i_out_stall)};

    // restoring divider, several quotient bits per cycle
    always_comb begin
        rem_v = {1'b0, r_rem};
        dvd_v = r_dvd;
        quo_v = r_target;
        for (int i = 0; i < DIV_BITS; i++) begin
            rem_v = {rem_v[REG_W-1:0], dvd_v[REG_W-1]};
            dvd_v = {dvd_v[REG_W-2:0], 1'b0};
            quo_v = {quo_v[REG_W-2:0], 1'b0};
            if (rem_v >= {1'b0, ramp}) begin
                rem_v    = rem_v - {1'b0, ramp};
                quo_v[0] = 1'b1;
            end
        end
    end

    // target register doubles as quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt) begin
            r_target <= t_pos ? i_cfg.max_current : '0;
            r_rem    <= tgt_prod[2*REG_W-1:REG_W];
            r_dvd    <= tgt_prod[REG_W-1:0];
        end else if (i_cmd.div_step) begin
            r_target <= quo_v;
            r_rem    <= rem_v[REG_W-1:0];
            r_dvd    <= dvd_v;
        end
    end

    // error magnitude and sign
    assign err     = $signed({2'b00, r_target}) - $signed({{2{r_meas[CUR_W-1]}}, r_meas});
    assign err_abs = err[REG_W+1] ? (REG_W+2)'(-err) : (REG_W+2)'(err);

    // round half away from zero, then slew limit
    assign rnd_sum = r_prod2 + PROD2_W'(32768);
    assign rounded = rnd_sum[PROD2_W-1:REG_W];
    assign lim     = (rounded > RND_W'(i_cfg.max_step)) ? i_cfg.max_step : rounded[REG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_err_neg <= err[REG_W+1];
            r_low     <= (r_target < MIN_TARGET);
            r_prod1   <= PROD1_W'(err_abs[REG_W:0]) * PROD1_W'(i_cfg.p_gain);
        end
        if (i_cmd.mul2) begin
            r_prod2 <= PROD2_W'(r_prod1) * PROD2_W'(i_cfg.pwm_range);
        end
        if (i_cmd.rnd) begin
            r_delta <= r_err_neg ? $signed((REG_W+1)'(0) - {1'b0, lim})
                                 : $signed({1'b0, lim});
        end
    end

    // accumulate with saturation, then clamp to the pwm range
    assign ch_ok   = (32'(r_ch) < CHANNELS);
    assign idx     = CH_W'(r_ch);
    assign acc_rd  = ch_ok ? r_acc[idx] : '0;
    assign acc_sum = $signed({acc_rd[ACC_W-1], acc_rd})
                   + $signed({{(ACC_W-REG_W){r_delta[REG_W]}}, r_delta});
    assign acc_sat = (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                   ? (acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}})
                   : acc_sum[ACC_W-1:0];
    assign acc_new = r_low ? '0 : acc_sat;

    always_comb begin
        if (acc_new[ACC_W-1] || (acc_new == '0)) begin
            duty = '0;
        end else if (acc_new > ACC_W'(i_cfg.pwm_range)) begin
            duty = i_cfg.pwm_range;
        end else begin
            duty = acc_new[REG_W-1:0];
        end
    end

    // stored duty per channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_acc[i] <= '0;
            end
        end else if (i_cmd.commit && ch_ok) begin
            r_acc[idx] <= acc_new;
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_ch   <= r_ch;
            r_out_duty <= ch_ok ? duty : '0;
            r_out_tgt  <= r_target;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_pwm_duty    = r_out_duty;
    assign o_setpoint    = r_out_tgt;

`ifndef SYNTHESIS
    // low target leaves a zero duty
    a_low_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_low |=> o_pwm_duty == '0)
        else $error("duty not cleared on low target");

    // missing channel gives zero duty
    a_bad_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && !ch_ok |=> o_pwm_duty == '0)
        else $error("duty nonzero for missing channel");

    // emitted duty never above full scale
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pwm_duty <= i_cfg.pwm_range)
        else $error("duty above pwm range");

    // after wake-up the target is full brightness
    a_full_tgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tgt && t_pos |=> r_target == i_cfg.max_current)
        else $error("target not full after wake-up");
`endif

endmodule

`default_nettype wire

[sv/led_current_p_loop_with_ramp.sv]
`default_nettype none

// each input beat is latched and its target formed; on the ramp (not at or after
// wake-up, nor before the ramp) the 16-bit ramp divide retires 4 quotient bits
// per cycle; the error path runs two registered multiplies, then the result beat
// is committed once the output is free; no new item is taken before the commit
// reset: synchronous active-low, registers return to defaults and every
// channel's stored duty clears to zero; no result pending after reset
module led_current_p_loop_with_ramp #(
    parameter int CHANNELS = lcpl_pkg::LCPL_CHANNELS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [lcpl_pkg::CH_FW-1:0]         i_channel,
    input  wire logic signed [lcpl_pkg::CUR_W-1:0]  i_measured_current,
    input  wire logic signed [lcpl_pkg::TIME_W-1:0] i_time_rel_wakeup,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [lcpl_pkg::CH_FW-1:0]              o_out_channel,
    output logic [lcpl_pkg::REG_W-1:0]              o_pwm_duty,
    output logic [lcpl_pkg::REG_W-1:0]              o_setpoint,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [lcpl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lcpl_pkg::REG_W-1:0]         i_cfg_data
);
    import lcpl_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // configuration registers
    lcpl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // sequencer
    lcpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // arithmetic and per-channel state
    lcpl_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_channel          (i_channel),
        .i_measured_current (i_measured_current),
        .i_time_rel_wakeup  (i_time_rel_wakeup),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_out_channel      (o_out_channel),
        .o_pwm_duty         (o_pwm_duty),
        .o_setpoint         (o_setpoint)
    );

endmodule

`default_nettype wire

[verif/led_current_p_loop_with_ramp_test.sv]
`default_nettype none

module led_current_p_loop_with_ramp_test;
    import lcpl_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int SAT_UPDATES  = 135;
    localparam longint ACC_HI   = 64'sd8388607;
    localparam longint ACC_LO   = -64'sd8388608;

    // register indexes that map to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic [CH_FW-1:0]         channel;
        logic signed [CUR_W-1:0]  measured;
        logic signed [TIME_W-1:0] time_rel;
    } t_reading;

    typedef struct {
        logic [CH_FW-1:0] channel;
        logic [REG_W-1:0] duty;
        logic [REG_W-1:0] target;
    } t_duty_update;

    // dut inputs, known from time zero
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic [CH_FW-1:0]         i_channel = '0;
    logic signed [CUR_W-1:0]  i_measured_current = '0;
    logic signed [TIME_W-1:0] i_time_rel_wakeup = '0;
    logic                     i_out_stall = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [REG_W-1:0]         i_cfg_data = '0;

    logic                     o_in_stall;
    logic                     o_out_valid;
    logic [CH_FW-1:0]         o_out_channel;
    logic [REG_W-1:0]         o_pwm_duty;
    logic [REG_W-1:0]         o_setpoint;
    logic                     o_cfg_ready;

    // shadow registers and per-channel duty state
    logic [REG_W-1:0]         p_gain;
    logic [REG_W-1:0]         max_step;
    logic [REG_W-1:0]         pwm_range;
    logic [REG_W-1:0]         max_current;
    logic [REG_W-1:0]         even_ramp;
    logic [REG_W-1:0]         odd_ramp;
    logic signed [ACC_W-1:0]  duty_acc [LCPL_CHANNELS];

    t_reading     pending_readings[$];
    t_duty_update expected_updates[$];
    int           readings_outstanding = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;

    // handshake flags between the clocked processes and the sequencer
    bit           in_fired = 1'b0;
    bit           cfg_taken = 1'b0;
    bit           quiet = 1'b0;
    bit           hold_request = 1'b0;
    int           hold_left = 0;
    int           send_gap = 0;
    int           recv_gap = 0;

    led_current_p_loop_with_ramp i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_channel          (i_channel),
        .i_measured_current (i_measured_current),
        .i_time_rel_wakeup  (i_time_rel_wakeup),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_channel      (o_out_channel),
        .o_pwm_duty         (o_pwm_duty),
        .o_setpoint         (o_setpoint),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // target from the ramp, then slew-limited proportional step on the duty
    function automatic t_duty_update regulate_channel(input t_reading r);
        t_duty_update u;
        longint tt, meas, ramp, tgt, err, mag, acc;
        longint pg, ms, pr, mc;
        tt   = longint'(r.time_rel);
        meas = longint'(r.measured);
        pg   = longint'(p_gain);
        ms   = longint'(max_step);
        pr   = longint'(pwm_range);
        mc   = longint'(max_current);
        ramp = r.channel[0] ? longint'(odd_ramp) : longint'(even_ramp);
        if (tt > 0) begin
            tgt = mc;
        end else if (tt < -ramp) begin
            tgt = 0;
        end else if (ramp == 0) begin
            tgt = mc;
        end else begin
            tgt = (mc * (ramp + tt)) / ramp;
        end
        acc = longint'(duty_acc[r.channel]);
        if (tgt < longint'(MIN_TARGET)) begin
            acc = 0;
        end else begin
            err = tgt - meas;
            mag = (err < 0) ? -err : err;
            // round half away from zero on the magnitude
            mag = (mag * pg * pr + 32768) >>> 16;
            if (mag > ms) mag = ms;
            acc = acc + ((err < 0) ? -mag : mag);
            if (acc > ACC_HI) acc = ACC_HI;
            if (acc < ACC_LO) acc = ACC_LO;
        end
        duty_acc[r.channel] = acc[ACC_W-1:0];
        u.channel = r.channel;
        if (acc <= 0) u.duty = '0;
        else if (acc > pr) u.duty = pr[REG_W-1:0];
        else u.duty = acc[REG_W-1:0];
        u.target = tgt[REG_W-1:0];
        return u;
    endfunction

    task automatic queue_reading(input int ch, input int meas, input longint t);
        t_reading r;
        r.channel  = ch[CH_FW-1:0];
        r.measured = meas[CUR_W-1:0];
        r.time_rel = t[TIME_W-1:0];
        pending_readings.push_back(r);
        readings_outstanding++;
    endtask

    // random reading, mostly on or near the ramp of the current settings
    function automatic t_reading random_reading();
        t_reading r;
        longint ramp, t;
        int meas;
        r.channel = CH_FW'($urandom_range(0, LCPL_CHANNELS - 1));
        ramp = r.channel[0] ? longint'(odd_ramp) : longint'(even_ramp);
        case ($urandom_range(0, 9))
            0: t = longint'($signed($urandom));
            1: t = longint'($urandom_range(1, 2000));
            2: t = -ramp - longint'($urandom_range(1, 2000));
            3: begin
                case ($urandom_range(0, 3))
                    0: t = 0;
                    1: t = 1;
                    2: t = -ramp;
                    default: t = -ramp - 1;
                endcase
            end
            default: t = -longint'($urandom_range(0, int'(ramp)));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            meas = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            meas = int'($urandom_range(0, (max_current > 32767) ? 32767 : int'(max_current)));
        end
        r.time_rel = t[TIME_W-1:0];
        r.measured = meas[CUR_W-1:0];
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge i_clk);
        cfg_taken   = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_regs(input int pg, input int ms, input int pr,
                            input int mc, input int er, input int orr);
        write_reg(CFG_P_GAIN,      pg[REG_W-1:0]);
        write_reg(CFG_MAX_STEP,    ms[REG_W-1:0]);
        write_reg(CFG_PWM_RANGE,   pr[REG_W-1:0]);
        write_reg(CFG_MAX_CURRENT, mc[REG_W-1:0]);
        write_reg(CFG_EVEN_RAMP,   er[REG_W-1:0]);
        write_reg(CFG_ODD_RAMP,    orr[REG_W-1:0]);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (readings_outstanding != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic int pick_ramp();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65535;
            2: return 1;
            default: return int'($urandom_range(2, 300));
        endcase
    endfunction

    // input driver: new beat only after the last one was taken
    always @(negedge i_clk) begin : reading_driver
        logic     v;
        t_reading r;
        v = i_in_valid;
        r.channel  = i_channel;
        r.measured = i_measured_current;
        r.time_rel = i_time_rel_wakeup;
        if (!i_rst_n) begin
            v = 1'b0;
        end else if (!v || in_fired) begin
            v = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_readings.size() != 0) begin
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    send_gap = int'($urandom_range(1, 13)) - 1;
                end else begin
                    r = pending_readings.pop_front();
                    v = 1'b1;
                end
            end
        end
        in_fired = 1'b0;
        i_in_valid         <= v;
        i_channel          <= r.channel;
        i_measured_current <= r.measured;
        i_time_rel_wakeup  <= r.time_rel;
    end

    // output side back-pressure, bursts plus one long hold-off
    always @(negedge i_clk) begin : duty_receiver
        logic s;
        s = 1'b0;
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            s = 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            s = 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = int'($urandom_range(1, 13)) - 1;
            s = 1'b1;
        end
        i_out_stall <= s;
    end

    // sample handshakes, predict on input beats, check on output beats
    always @(posedge i_clk) begin : duty_monitor
        t_reading     r;
        t_duty_update e;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                r.channel  = i_channel;
                r.measured = i_measured_current;
                r.time_rel = i_time_rel_wakeup;
                expected_updates.push_back(regulate_channel(r));
                in_fired = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_P_GAIN:      p_gain      = i_cfg_data;
                    CFG_MAX_STEP:    max_step    = i_cfg_data;
                    CFG_PWM_RANGE:   pwm_range   = i_cfg_data;
                    CFG_MAX_CURRENT: max_current = i_cfg_data;
                    CFG_EVEN_RAMP:   even_ramp   = i_cfg_data;
                    CFG_ODD_RAMP:    odd_ramp    = i_cfg_data;
                    default: ;
                endcase
                cfg_taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_updates.size() == 0) begin
                    $display("%0t: unexpected result beat ch=%0d duty=%0d target=%0d",
                             $realtime, o_out_channel, o_pwm_duty, o_setpoint);
                    mismatch_count++;
                end else begin
                    e = expected_updates.pop_front();
                    readings_outstanding--;
                    if (o_out_channel !== e.channel) begin
                        $display("%0t: out_channel expected %0d actual %0d",
                                 $realtime, e.channel, o_out_channel);
                        mismatch_count++;
                    end
                    if (o_pwm_duty !== e.duty) begin
                        $display("%0t: pwm_duty expected %0d actual %0d",
                                 $realtime, e.duty, o_pwm_duty);
                        mismatch_count++;
                    end
                    if (o_setpoint !== e.target) begin
                        $display("%0t: target expected %0d actual %0d",
                                 $realtime, e.target, o_setpoint);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // test sequence
    initial begin : sequencer
        p_gain      = RST_P_GAIN;
        max_step    = RST_MAX_STEP;
        pwm_range   = RST_PWM_RANGE;
        max_current = RST_MAX_CURRENT;
        even_ramp   = RST_EVEN_RAMP;
        odd_ramp    = RST_ODD_RAMP;
        for (int i = 0; i < LCPL_CHANNELS; i++) duty_acc[i] = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: wake-up edges, ramp ends, threshold either side
        queue_reading(0, 0, 0);
        queue_reading(1, 0, 1);
        queue_reading(2, -32768, 64'sd2147483647);
        queue_reading(3, 32767, -1);
        queue_reading(0, 100, -2560);
        queue_reading(0, 100, -2561);
        queue_reading(1, 0, -5120);
        queue_reading(1, 0, -5121);
        queue_reading(2, 0, -64'sd2147483648);
        queue_reading(0, 0, -2535);
        queue_reading(0, 0, -2534);
        queue_reading(3, -1, -2560);
        wait_drained();

        // every register at its top value
        set_regs(65535, 65535, 65535, 65535, 65535, 65535);
        queue_reading(0, -32768, 1);
        queue_reading(1, 32767, -1);
        queue_reading(2, -32768, -65535);
        queue_reading(3, 32767, -65536);
        queue_reading(0, 0, -32768);
        wait_drained();

        // zero ramps, zero range and gain, target right at threshold
        set_regs(0, 0, 0, 41, 0, 0);
        write_reg(CFG_SPARE_LO, 16'hffff);
        write_reg(CFG_SPARE_HI, 16'hffff);
        queue_reading(0, 0, 0);
        queue_reading(1, 0, -1);
        queue_reading(2, -32768, 1);
        queue_reading(3, 32767, 0);
        wait_drained();

        // drive one channel up and one down into accumulator saturation
        set_regs(65535, 65535, 65535, 65535, 65535, 65535);
        for (int i = 0; i < SAT_UPDATES; i++) begin
            queue_reading(0, -int'($urandom_range(0, 32768)),
                          longint'($urandom_range(1, 32'h7fffffff)));
            queue_reading(1, 32767 - int'($urandom_range(0, 1000)),
                          -65535 + longint'($urandom_range(41, 200)));
        end
        wait_drained();

        // random settings; the first phase also holds off the receiver
        for (int ph = 0; ph < 4; ph++) begin
            set_regs(int'($urandom_range(0, 65535)),
                     ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                                 : int'($urandom_range(0, 50)),
                     ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1))
                                                 : int'($urandom_range(2, 65535)),
                     ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 65535)),
                     pick_ramp(), pick_ramp());
            if (ph == 0) hold_request = 1'b1;
            for (int i = 0; i < 50; i++) begin
                pending_readings.push_back(random_reading());
                readings_outstanding++;
            end
            wait_drained();
        end

        // last stretch at full rate on both sides
        set_regs(RST_P_GAIN, RST_MAX_STEP, RST_PWM_RANGE, RST_MAX_CURRENT, 40, 90);
        quiet = 1'b1;
        for (int i = 0; i < 50; i++) begin
            pending_readings.push_back(random_reading());
            readings_outstanding++;
        end
        wait_drained();

        if (mismatch_count == 0 && expected_updates.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
